// File: rtl/cht_pkg.sv
// ----------------------------------------------------------------------------
// Chained hash table package
// Function codes, hash constants and controller state encoding.
// ----------------------------------------------------------------------------
`default_nettype none

package cht_pkg;

    localparam logic [2:0] FUNC_SEARCH = 3'd0;
    localparam logic [2:0] FUNC_LOOKUP = 3'd1;
    localparam logic [2:0] FUNC_INSERT = 3'd2;
    localparam logic [2:0] FUNC_REMOVE = 3'd3;
    localparam logic [2:0] FUNC_CLEAR  = 3'd4;

    localparam logic [31:0] GOLDEN_MUL = 32'd2654435761;
    localparam int          FOLD_SHIFT = 31;

    typedef enum logic [8:0] {
        S_IDLE = 9'b000000001,
        S_MUL  = 9'b000000010,
        S_FOLD = 9'b000000100,
        S_BKT  = 9'b000001000,
        S_HEAD = 9'b000010000,
        S_WALK = 9'b000100000,
        S_UPD  = 9'b001000000,
        S_OUT  = 9'b010000000,
        S_CLR  = 9'b100000000
    } t_state;

endpackage

`default_nettype wire

// File: rtl/cht_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module cht_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// File: rtl/cht_hash.sv
// ----------------------------------------------------------------------------
// Chained hash table key hash
// Two-stage multiplicative hash of a 64-bit key down to a bucket index.
// ----------------------------------------------------------------------------
`default_nettype none

module cht_hash
    import cht_pkg::*;
#(
    parameter int BUCKET_COUNT = 256
) (
    input  wire logic                            i_clk,
    input  wire logic [63:0]                     i_key,
    output logic      [$clog2(BUCKET_COUNT)-1:0] o_bucket
);

    localparam int BW = $clog2(BUCKET_COUNT);

    logic [63:0] r_p_hi;
    logic [63:0] r_p_lo;
    logic [31:0] r_h_hi;
    logic [31:0] r_h_lo;
    logic [31:0] w_f_hi;
    logic [31:0] w_f_lo;
    logic [31:0] w_h;

    always_ff @(posedge i_clk) begin
        r_p_hi <= 64'(i_key[63:32]) * 64'(GOLDEN_MUL);
        r_p_lo <= 64'(i_key[31:0]) * 64'(GOLDEN_MUL);
        r_h_hi <= r_p_hi[31:0] + r_p_hi[FOLD_SHIFT +: 32];
        r_h_lo <= r_p_lo[31:0] + r_p_lo[FOLD_SHIFT +: 32];
    end

    assign w_f_hi   = r_h_hi + 32'(r_h_hi[FOLD_SHIFT]);
    assign w_f_lo   = r_h_lo + 32'(r_h_lo[FOLD_SHIFT]);
    assign w_h      = w_f_hi ^ w_f_lo;
    assign o_bucket = w_h[BW-1:0] & BW'(BUCKET_COUNT - 1);

endmodule

`default_nettype wire

// File: rtl/chained_hash_table_top.sv
// ----------------------------------------------------------------------------
// Chained hash table
// Key-value table with separate chaining over a fixed entry pool.
//
//   channel | direction | valid        | stall        | payload
//   in      | input     | i_in_valid   | o_in_stall   | i_func, i_key, i_value
//   out     | output    | o_out_valid  | i_out_stall  | o_found, o_result_value,
//           |           |              |              | o_status, o_entry_count
//
// A word passes the hash pipeline (S_MUL, S_FOLD, S_BKT), the bucket head
// read (S_HEAD), the entry memory read loop over the chain (S_WALK), the
// update (S_UPD) and S_OUT; the next word is taken once the state is idle
// again. Unknown codes skip the walk and the update.
// Clear answers after a sweep of the bucket memory.
// After reset the same sweep runs with o_in_stall high.
// A stalled result is held; the next word is taken and worked meanwhile.
// ----------------------------------------------------------------------------
`default_nettype none

module chained_hash_table_top
    import cht_pkg::*;
#(
    parameter int BUCKET_COUNT = 256,
    parameter int POOL_ENTRIES = 256,
    parameter int VALUE_BITS   = 32
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [2:0]  i_func,
    input  wire logic [63:0] i_key,
    input  wire logic [31:0] i_value,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic             o_found,
    output logic [31:0]      o_result_value,
    output logic             o_status,
    output logic [8:0]       o_entry_count
);

    localparam int BW  = $clog2(BUCKET_COUNT);
    localparam int IW  = $clog2(POOL_ENTRIES);
    localparam int CW  = $clog2(POOL_ENTRIES + 1);
    localparam int SVB = (VALUE_BITS < 32) ? VALUE_BITS : 32;
    localparam int HW  = IW + 1;
    localparam int EW  = 64 + SVB + 1 + IW;

    t_state           r_state;
    t_state           n_state;
    logic [2:0]       r_func;
    logic [63:0]      r_key;
    logic [SVB-1:0]   r_value;
    logic [BW-1:0]    r_bucket;
    logic [HW-1:0]    r_head;
    logic             r_found;
    logic             r_have_prev;
    logic [IW-1:0]    r_cur;
    logic [IW-1:0]    r_prev;
    logic [EW-1:0]    r_cur_ent;
    logic [EW-1:0]    r_prev_ent;
    logic [CW-1:0]    r_live;
    logic [CW-1:0]    r_hw;
    logic [BW-1:0]    r_sweep;
    logic             r_res_pending;
    logic             r_res_found;
    logic [31:0]      r_res_value;
    logic             r_res_status;

    logic [BW-1:0]    w_bucket;
    logic [HW-1:0]    w_head_rdata;
    logic             w_head_we;
    logic [BW-1:0]    w_head_waddr;
    logic [HW-1:0]    w_head_wdata;
    logic [EW-1:0]    w_ent_rdata;
    logic             w_ent_we;
    logic [IW-1:0]    w_ent_waddr;
    logic [EW-1:0]    w_ent_wdata;
    logic [IW-1:0]    w_ent_raddr;
    logic [IW-1:0]    w_free_rdata;
    logic             w_free_we;
    logic [IW-1:0]    w_free_waddr;
    logic [IW-1:0]    w_free_raddr;

    logic             w_accept;
    logic             w_out_free;
    logic             w_is_ins;
    logic             w_is_rem;
    logic             w_full;
    logic [IW-1:0]    w_alloc;
    logic [SVB-1:0]   w_nv;
    logic             w_key_hit;

    cht_hash #(
        .BUCKET_COUNT (BUCKET_COUNT)
    ) u_hash (
        .i_clk    (i_clk),
        .i_key    (r_key),
        .o_bucket (w_bucket)
    );

    cht_ram #(.WIDTH(HW), .DEPTH(BUCKET_COUNT)) u_head_ram (
        .i_clk   (i_clk),
        .i_we    (w_head_we),
        .i_waddr (w_head_waddr),
        .i_wdata (w_head_wdata),
        .i_raddr (w_bucket),
        .o_rdata (w_head_rdata)
    );

    cht_ram #(.WIDTH(EW), .DEPTH(POOL_ENTRIES)) u_entry_ram (
        .i_clk   (i_clk),
        .i_we    (w_ent_we),
        .i_waddr (w_ent_waddr),
        .i_wdata (w_ent_wdata),
        .i_raddr (w_ent_raddr),
        .o_rdata (w_ent_rdata)
    );

    cht_ram #(.WIDTH(IW), .DEPTH(POOL_ENTRIES)) u_free_ram (
        .i_clk   (i_clk),
        .i_we    (w_free_we),
        .i_waddr (w_free_waddr),
        .i_wdata (r_cur),
        .i_raddr (w_free_raddr),
        .o_rdata (w_free_rdata)
    );

    assign o_in_stall = (r_state != S_IDLE);
    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_out_free = !o_out_valid || !i_out_stall;

    assign w_is_ins  = ((r_func == FUNC_LOOKUP) || (r_func == FUNC_INSERT)) && !r_found;
    assign w_is_rem  = (r_func == FUNC_REMOVE) && r_found;
    assign w_full    = (r_live >= CW'(POOL_ENTRIES));
    assign w_alloc   = (r_live < r_hw) ? w_free_rdata : IW'(r_live);
    assign w_nv      = (r_func == FUNC_INSERT) ? r_value : '0;
    assign w_key_hit = (w_ent_rdata[EW-1 -: 64] == r_key);

    assign w_free_raddr = IW'(POOL_ENTRIES - 1 - int'(r_live));
    assign w_free_waddr = IW'(POOL_ENTRIES - int'(r_live));
    assign w_free_we    = (r_state == S_UPD) && w_is_rem;

    assign w_ent_raddr = (r_state == S_HEAD) ? w_head_rdata[IW-1:0] : w_ent_rdata[IW-1:0];

    always_comb begin
        w_head_we    = 1'b0;
        w_head_waddr = r_bucket;
        w_head_wdata = {1'b1, w_alloc};
        w_ent_we     = 1'b0;
        w_ent_waddr  = w_alloc;
        w_ent_wdata  = {r_key, w_nv, r_head};
        if (r_state == S_CLR) begin
            w_head_we    = 1'b1;
            w_head_waddr = r_sweep;
            w_head_wdata = '0;
        end else if (r_state == S_UPD) begin
            if (w_is_ins && !w_full) begin
                w_head_we = 1'b1;
                w_ent_we  = 1'b1;
            end else if (w_is_rem) begin
                if (r_have_prev) begin
                    w_ent_we    = 1'b1;
                    w_ent_waddr = r_prev;
                    w_ent_wdata = {r_prev_ent[EW-1:HW], r_cur_ent[HW-1:0]};
                end else begin
                    w_head_we    = 1'b1;
                    w_head_wdata = r_cur_ent[HW-1:0];
                end
            end
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: if (w_accept) n_state = S_MUL;
            S_MUL:  n_state = S_FOLD;
            S_FOLD: n_state = S_BKT;
            S_BKT:  n_state = S_HEAD;
            S_HEAD: begin
                if (r_func == FUNC_CLEAR) begin
                    n_state = S_CLR;
                end else if (r_func > FUNC_CLEAR) begin
                    n_state = S_OUT;
                end else if (w_head_rdata[IW]) begin
                    n_state = S_WALK;
                end else begin
                    n_state = S_UPD;
                end
            end
            S_WALK: if (w_key_hit || !w_ent_rdata[IW]) n_state = S_UPD;
            S_UPD:  n_state = S_OUT;
            S_OUT:  if (w_out_free) n_state = S_IDLE;
            S_CLR: begin
                if (r_sweep == BW'(BUCKET_COUNT - 1)) begin
                    n_state = r_res_pending ? S_OUT : S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_CLR;
            r_sweep       <= '0;
            r_res_pending <= 1'b0;
            r_live        <= '0;
            r_hw          <= '0;
            o_out_valid   <= 1'b0;
        end else begin
            r_state <= n_state;
            case (r_state)
                S_IDLE: begin
                    r_func        <= i_func;
                    r_key         <= i_key;
                    r_value       <= i_value[SVB-1:0];
                    r_found       <= 1'b0;
                    r_have_prev   <= 1'b0;
                    r_res_found   <= 1'b0;
                    r_res_value   <= '0;
                    r_res_status  <= 1'b0;
                end
                S_BKT: r_bucket <= w_bucket;
                S_HEAD: begin
                    r_head <= w_head_rdata;
                    r_cur  <= w_head_rdata[IW-1:0];
                    if (r_func == FUNC_CLEAR) begin
                        r_live        <= '0;
                        r_hw          <= '0;
                        r_sweep       <= '0;
                        r_res_pending <= 1'b1;
                    end
                end
                S_WALK: begin
                    if (w_key_hit) begin
                        r_found   <= 1'b1;
                        r_cur_ent <= w_ent_rdata;
                    end else begin
                        r_have_prev <= 1'b1;
                        r_prev      <= r_cur;
                        r_prev_ent  <= w_ent_rdata;
                        r_cur       <= w_ent_rdata[IW-1:0];
                    end
                end
                S_UPD: begin
                    if (r_found) begin
                        r_res_found <= 1'b1;
                        r_res_value <= 32'(r_cur_ent[HW +: SVB]);
                    end
                    if (w_is_ins) begin
                        if (w_full) begin
                            r_res_status <= 1'b1;
                        end else begin
                            r_res_value <= 32'(w_nv);
                            r_live      <= r_live + CW'(1);
                            if (r_live == r_hw) begin
                                r_hw <= r_hw + CW'(1);
                            end
                        end
                    end else if (w_is_rem) begin
                        r_live <= r_live - CW'(1);
                    end
                end
                S_CLR: begin
                    r_sweep <= r_sweep + BW'(1);
                    if (r_sweep == BW'(BUCKET_COUNT - 1)) begin
                        r_res_pending <= 1'b0;
                    end
                end
                default: ;
            endcase
            if ((r_state == S_OUT) && w_out_free) begin
                o_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                o_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == S_OUT) && w_out_free) begin
            o_found        <= r_res_found;
            o_result_value <= r_res_value;
            o_status       <= r_res_status;
            o_entry_count  <= 9'(r_live);
        end
    end

endmodule

`default_nettype wire

// File: rtl/cht_checker.sv
// ----------------------------------------------------------------------------
// Chained hash table checker
// Port-level properties, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module cht_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_in_valid,
    input wire logic        o_in_stall,
    input wire logic [2:0]  i_func,
    input wire logic [63:0] i_key,
    input wire logic [31:0] i_value,
    input wire logic        o_out_valid,
    input wire logic        i_out_stall,
    input wire logic        o_found,
    input wire logic [31:0] o_result_value,
    input wire logic        o_status,
    input wire logic [8:0]  o_entry_count
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_result_value)
            && $stable(o_entry_count))
        else $error("result word changed while stalled");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("word taken while previous word in work");

    a_full_no_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status |-> !o_found && (o_result_value == 32'd0))
        else $error("refused insert reports a value");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_stall ##1 o_out_valid && o_status
            |-> o_entry_count == $past(o_entry_count))
        else $error("count moved on refused insert");

endmodule

bind chained_hash_table_top cht_checker u_cht_checker (.*);

`default_nettype wire

// File: tb/tb.sv
// ----------------------------------------------------------------------------
// Chained hash table testbench
// Drives search, lookup, insert, remove and clear words into the table and
// checks every result against a behavioral table kept in the bench, under
// several sender and receiver idle patterns and one long receiver hold-off.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb
    import cht_pkg::*;
();

    localparam int NB = 256;
    localparam int NP = 256;
    localparam int WATCH_LIMIT = 20000;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    logic [2:0]  i_func;
    logic [63:0] i_key;
    logic [31:0] i_value;
    logic        o_out_valid;
    logic        i_out_stall;
    logic        o_found;
    logic [31:0] o_result_value;
    logic        o_status;
    logic [8:0]  o_entry_count;

    chained_hash_table_top DUT (.*);

    typedef struct packed {
        logic        found;
        logic [31:0] rval;
        logic        status;
        logic [8:0]  count;
    } t_result;

    // predicted table
    logic        head_v[NB];
    logic [8:0]  head_i[NB];
    logic [63:0] ekey[NP];
    logic [31:0] eval[NP];
    logic        nxt_v[NP];
    logic [8:0]  nxt_i[NP];
    logic [8:0]  free_stk[NP];
    int          live;

    t_result     pending_results[$];
    logic [63:0] used_keys[$];
    int          errors = 0;
    int          n_sent = 0;
    int          n_checked = 0;
    int          idle_pct = 0;
    int          stall_pct = 0;
    bit          hold_off = 0;
    int          quiet = 0;

    initial begin
        i_clk = 0;
        forever #4 i_clk = ~i_clk;
    end

    function automatic logic [31:0] fold(input logic [31:0] n);
        logic [63:0] p;
        logic [31:0] h;
        p = 64'(n) * 64'(GOLDEN_MUL);
        h = 32'(p + (p >> FOLD_SHIFT));
        return h + (h >> FOLD_SHIFT);
    endfunction

    function automatic int bucket_of(input logic [63:0] k);
        logic [31:0] h;
        h = fold(k[63:32]) ^ fold(k[31:0]);
        return int'(h & 32'(NB - 1));
    endfunction

    function automatic void table_clear();
        for (int b = 0; b < NB; b++) head_v[b] = 0;
        for (int i = 0; i < NP; i++) free_stk[i] = 9'(NP - 1 - i);
        live = 0;
    endfunction

    function automatic t_result apply_op(input logic [2:0] f, input logic [63:0] k,
                                         input logic [31:0] v);
        t_result r;
        int b, cur, prv, ci, steps, idx;
        bit have, have_prv, cv;
        r = '0;
        b = bucket_of(k);
        have = 0; have_prv = 0; cur = 0; prv = 0; steps = 0;
        cv = head_v[b];
        ci = head_i[b];
        if (f <= FUNC_REMOVE) begin
            while (cv && steps < NP) begin
                if (ekey[ci] == k) begin
                    have = 1;
                    cur = ci;
                    break;
                end
                have_prv = 1;
                prv = ci;
                cv = nxt_v[ci];
                ci = nxt_i[ci];
                steps++;
            end
        end
        if (f <= FUNC_INSERT && have) begin
            r.found = 1;
            r.rval = eval[cur];
        end else if ((f == FUNC_LOOKUP || f == FUNC_INSERT) && !have) begin
            if (live >= NP) begin
                r.status = 1;
            end else begin
                idx = free_stk[NP - 1 - live];
                ekey[idx] = k;
                eval[idx] = (f == FUNC_INSERT) ? v : 32'd0;
                nxt_v[idx] = head_v[b];
                nxt_i[idx] = head_i[b];
                head_v[b] = 1;
                head_i[b] = 9'(idx);
                live++;
                r.rval = eval[idx];
            end
        end else if (f == FUNC_REMOVE && have) begin
            r.found = 1;
            r.rval = eval[cur];
            if (have_prv) begin
                nxt_v[prv] = nxt_v[cur];
                nxt_i[prv] = nxt_i[cur];
            end else begin
                head_v[b] = nxt_v[cur];
                head_i[b] = nxt_i[cur];
            end
            free_stk[NP - live] = 9'(cur);
            live--;
        end else if (f == FUNC_CLEAR) begin
            table_clear();
        end
        r.count = 9'(live);
        return r;
    endfunction

    task automatic send_word(input logic [2:0] f, input logic [63:0] k,
                             input logic [31:0] v);
        while ($urandom_range(99, 0) < idle_pct) begin
            i_in_valid <= 0;
            @(negedge i_clk);
        end
        i_in_valid <= 1;
        i_func <= f;
        i_key <= k;
        i_value <= v;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        pending_results.push_back(apply_op(f, k, v));
        if (f == FUNC_LOOKUP || f == FUNC_INSERT) used_keys.push_back(k);
        n_sent++;
        @(negedge i_clk);
    endtask

    function automatic logic [63:0] pick_key();
        if (used_keys.size() > 0 && $urandom_range(3, 0) != 0)
            return used_keys[$urandom_range(used_keys.size() - 1, 0)];
        return {$urandom, $urandom};
    endfunction

    task automatic send_random(input int n, input int clear_odds);
        logic [2:0] f;
        int r;
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(99, 0);
            if (r < clear_odds) f = FUNC_CLEAR;
            else if (r < 97) f = 3'($urandom_range(3, 0));
            else f = 3'($urandom_range(7, 5));
            send_word(f, pick_key(), $urandom);
        end
    endtask

    task automatic drain();
        i_in_valid <= 0;
        while (pending_results.size() > 0) @(posedge i_clk);
        repeat (NB + 20) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic test_directed();
        send_word(FUNC_SEARCH, 64'd0, 32'd0);
        send_word(FUNC_INSERT, 64'd0, 32'hFFFF_FFFF);
        send_word(FUNC_INSERT, 64'hFFFF_FFFF_FFFF_FFFF, 32'd0);
        send_word(FUNC_INSERT, 64'd0, 32'h1234_5678);
        send_word(FUNC_LOOKUP, 64'h8000_0000_0000_0001, 32'hFFFF_FFFF);
        send_word(FUNC_LOOKUP, 64'd0, 32'd0);
        send_word(FUNC_SEARCH, 64'hFFFF_FFFF_FFFF_FFFF, 32'd0);
        send_word(FUNC_REMOVE, 64'd0, 32'd0);
        send_word(FUNC_REMOVE, 64'd0, 32'd0);
        send_word(FUNC_SEARCH, 64'd0, 32'd0);
        send_word(3'd5, 64'd1, 32'd1);
        send_word(3'd6, 64'd2, 32'd2);
        send_word(3'd7, 64'd3, 32'd3);
        send_word(FUNC_CLEAR, 64'd0, 32'd0);
        send_word(FUNC_SEARCH, 64'h8000_0000_0000_0001, 32'd0);
    endtask

    // fill the pool past full, then empty it again
    task automatic test_pool_full();
        for (int i = 0; i < NP + 3; i++)
            send_word(($urandom_range(1, 0) != 0) ? FUNC_INSERT : FUNC_LOOKUP,
                      {32'($urandom_range(3, 0)), 32'(i)}, $urandom);
        for (int i = 0; i < 40; i++)
            send_word(FUNC_REMOVE, used_keys[$urandom_range(used_keys.size() - 1, 0)],
                      32'd0);
        send_word(FUNC_CLEAR, 64'd0, 32'd0);
        used_keys.delete();
    endtask

    task automatic test_random_phase(input int idle, input int stall, input int n);
        idle_pct = idle;
        stall_pct = stall;
        send_random(n, 2);
        drain();
    endtask

    task automatic test_hold_off();
        hold_off = 1;
        fork
            begin
                repeat (400) @(negedge i_clk);
                hold_off = 0;
            end
            send_random(20, 0);
        join
        drain();
    endtask

    always @(negedge i_clk) begin
        if (hold_off) i_out_stall <= 1;
        else i_out_stall <= ($urandom_range(99, 0) < stall_pct);
    end

    always @(posedge i_clk) begin
        t_result exp_r;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            n_checked++;
            if (pending_results.size() == 0) begin
                $display("%0t: result with nothing expected: %b %h %b %0d", $time,
                         o_found, o_result_value, o_status, o_entry_count);
                errors++;
            end else begin
                exp_r = pending_results.pop_front();
                if (o_found !== exp_r.found || o_result_value !== exp_r.rval
                    || o_status !== exp_r.status || o_entry_count !== exp_r.count) begin
                    $display("%0t: expected %b %h %b %0d, got %b %h %b %0d", $time,
                             exp_r.found, exp_r.rval, exp_r.status, exp_r.count,
                             o_found, o_result_value, o_status, o_entry_count);
                    errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) quiet <= 0;
        else quiet <= quiet + 1;
        if (quiet >= WATCH_LIMIT) begin
            $display("tb: done, errors");
            $finish;
        end
    end

    initial begin
        i_rst_n = 0;
        i_in_valid = 0;
        i_out_stall = 0;
        i_func = 0;
        i_key = 0;
        i_value = 0;
        table_clear();
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1;
        test_directed();
        drain();
        test_pool_full();
        drain();
        test_random_phase(0, 0, 90);
        test_random_phase(47, 0, 90);
        test_random_phase(0, 47, 90);
        test_random_phase(27, 27, 90);
        test_hold_off();
        if (pending_results.size() > 0) begin
            $display("%0t: %0d results never arrived", $time, pending_results.size());
            errors++;
        end
        $display("tb: %0d words sent, %0d results checked; all functions, full pool,",
                 n_sent, n_checked);
        $display("tb: clear, unknown codes, idle/stall phases and a long output hold-off");
        if (errors == 0) $display("tb: done, clean");
        else $display("tb: done, errors");
        $finish;
    end

endmodule
